>>> sv/dpb_pkg.sv
// Package for the depth pixel back-projection core: constants, register codes and shared types.
package dpb_pkg;

   // Default values of the design parameters.
   localparam int COORD_FRAC_BITS_DEF  = 16;
   localparam int POINT_INDEX_BITS_DEF = 19;
   localparam int PIXEL_COORD_BITS_DEF = 12;

   // Fixed widths of the interface fields.
   localparam int DEPTH_BITS    = 16;
   localparam int COLOUR_BITS   = 8;
   localparam int RECIP_BITS    = 24;
   localparam int CENTER_BITS   = 13;
   localparam int WIDTH_BITS    = 12;
   localparam int POINTS_BITS   = 20;
   localparam int COORD_BITS    = 32;
   localparam int Z_BITS        = 24;
   localparam int INDEX_BITS    = 19;
   localparam int CSR_IDX_BITS  = 3;
   localparam int CSR_DATA_BITS = 24;

   // Configuration register indexes.
   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_DEPTH_RECIP   = 3'd0,
      CSR_CENTER_X_HALF = 3'd1,
      CSR_CENTER_Y_HALF = 3'd2,
      CSR_RECIP_FX      = 3'd3,
      CSR_RECIP_FY      = 3'd4,
      CSR_FRAME_WIDTH   = 3'd5,
      CSR_MAX_POINTS    = 3'd6
   } csr_index_type;

   // Register values after reset.
   localparam logic        [RECIP_BITS-1:0]  DEPTH_RECIP_RST   = 24'd3355;
   localparam logic        [CENTER_BITS-1:0] CENTER_X_HALF_RST = 13'd639;
   localparam logic        [CENTER_BITS-1:0] CENTER_Y_HALF_RST = 13'd479;
   localparam logic signed [RECIP_BITS-1:0]  RECIP_FX_RST      = 24'sd34865;
   localparam logic signed [RECIP_BITS-1:0]  RECIP_FY_RST      = -24'sd34953;
   localparam logic        [WIDTH_BITS-1:0]  FRAME_WIDTH_RST   = 12'd640;
   localparam logic        [POINTS_BITS-1:0] MAX_POINTS_RST    = 20'd500000;

   // Point counter saturates here.
   localparam logic [POINTS_BITS-1:0] POINTS_SAT = '1;

   // Commands from the sequencer to the datapath.
   typedef struct packed {
      logic accept;    // take the input pixel, advance counters, form the raw depth product
      logic zfin;      // round and saturate the depth
      logic mul_zr;    // depth times reciprocal focal length
      logic mul_lo;    // low half of that product times the pixel offset
      logic mul_hi;    // high half, accumulated
      logic fin;       // round and saturate the coordinate
      logic axis;      // 0 for x, 1 for y
      logic load_out;  // move the finished point into the output register
   } dpb_cmd_type;

   // Status from the datapath to the sequencer.
   typedef struct packed {
      logic depth_zero;  // the offered pixel has no measurement
   } dpb_status_type;

endpackage

>>> sv/depth_pixel_backprojection_core.sv
// Top level of the depth pixel back-projection core.
//
// Depth pixels arrive in raster order on the req_ channel; each carries a 16-bit raw depth,
// a start-of-frame flag and a BGR colour. The core keeps column and row counters, which
// advance on every pixel transfer, and a point counter, and turns every pixel with non-zero
// depth into one point on the rsp_ channel: z is the depth times the reciprocal depth scale,
// rounded and saturated to unsigned Q8.16 (with the default fraction width), and x and y are
// the pixel's half-pixel offset from the principal point times z times the reciprocal focal
// length, rounded half away from zero and saturated to signed Q15.16. Colour, the point's
// index within the frame and an overflow flag (set once max_points points have been given in
// the frame) travel with the point. A pixel with zero depth gives no transfer. A pixel with
// depth is taken in and its depth product formed, the depth is rounded, then x and y are each
// worked out on a single shared 24 by 24 bit multiplier (depth times reciprocal focal length,
// then the two 24-bit halves of that product times the offset, accumulated, then rounding),
// and the point is moved into the output register; no new pixel is taken before that move.
// The output register holds a finished point until it is taken, so the next pixel is accepted
// while a point still waits on a stalled rsp_ channel. Configuration is written through the
// csr_ port, which is always ready; the user must write it only while the core is idle, as
// the core does not enforce this. All seven registers take their documented values on reset.
module depth_pixel_backprojection_core #(
   parameter int COORD_FRAC_BITS  = dpb_pkg::COORD_FRAC_BITS_DEF,
   parameter int POINT_INDEX_BITS = dpb_pkg::POINT_INDEX_BITS_DEF,
   parameter int PIXEL_COORD_BITS = dpb_pkg::PIXEL_COORD_BITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // Pixel input channel.
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic                                  req_start_of_frame,
   input  logic [dpb_pkg::DEPTH_BITS-1:0]        req_depth_raw,
   input  logic [dpb_pkg::COLOUR_BITS-1:0]       req_blue,
   input  logic [dpb_pkg::COLOUR_BITS-1:0]       req_green,
   input  logic [dpb_pkg::COLOUR_BITS-1:0]       req_red,
   // Point output channel.
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [dpb_pkg::COORD_BITS-1:0] rsp_point_x,
   output logic signed [dpb_pkg::COORD_BITS-1:0] rsp_point_y,
   output logic [dpb_pkg::Z_BITS-1:0]            rsp_point_z,
   output logic [dpb_pkg::COLOUR_BITS-1:0]       rsp_out_blue,
   output logic [dpb_pkg::COLOUR_BITS-1:0]       rsp_out_green,
   output logic [dpb_pkg::COLOUR_BITS-1:0]       rsp_out_red,
   output logic [dpb_pkg::INDEX_BITS-1:0]        rsp_point_index,
   output logic                                  rsp_overflow,
   // Configuration write channel.
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [dpb_pkg::CSR_IDX_BITS-1:0]      csr_index,
   input  logic [dpb_pkg::CSR_DATA_BITS-1:0]     csr_data
);
   import dpb_pkg::*;

   dpb_cmd_type    cmd;
   dpb_status_type status;

   // Register writes complete in the cycle they are offered.
   assign csr_ready = 1'b1;

   dpb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   dpb_datapath #(
      .COORD_FRAC_BITS  (COORD_FRAC_BITS),
      .POINT_INDEX_BITS (POINT_INDEX_BITS),
      .PIXEL_COORD_BITS (PIXEL_COORD_BITS)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .csr_valid          (csr_valid && csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data),
      .req_start_of_frame (req_start_of_frame),
      .req_depth_raw      (req_depth_raw),
      .req_blue           (req_blue),
      .req_green          (req_green),
      .req_red            (req_red),
      .rsp_point_x        (rsp_point_x),
      .rsp_point_y        (rsp_point_y),
      .rsp_point_z        (rsp_point_z),
      .rsp_out_blue       (rsp_out_blue),
      .rsp_out_green      (rsp_out_green),
      .rsp_out_red        (rsp_out_red),
      .rsp_point_index    (rsp_point_index),
      .rsp_overflow       (rsp_overflow)
   );

endmodule

>>> sv/dpb_datapath.sv
// Datapath of the depth pixel back-projection core: registers, counters, multiplier and output stage.
module dpb_datapath #(
   parameter int COORD_FRAC_BITS  = dpb_pkg::COORD_FRAC_BITS_DEF,
   parameter int POINT_INDEX_BITS = dpb_pkg::POINT_INDEX_BITS_DEF,
   parameter int PIXEL_COORD_BITS = dpb_pkg::PIXEL_COORD_BITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  dpb_pkg::dpb_cmd_type                  cmd,
   output dpb_pkg::dpb_status_type               status,
   input  logic                                  csr_valid,
   input  logic [dpb_pkg::CSR_IDX_BITS-1:0]      csr_index,
   input  logic [dpb_pkg::CSR_DATA_BITS-1:0]     csr_data,
   input  logic                                  req_start_of_frame,
   input  logic [dpb_pkg::DEPTH_BITS-1:0]        req_depth_raw,
   input  logic [dpb_pkg::COLOUR_BITS-1:0]       req_blue,
   input  logic [dpb_pkg::COLOUR_BITS-1:0]       req_green,
   input  logic [dpb_pkg::COLOUR_BITS-1:0]       req_red,
   output logic signed [dpb_pkg::COORD_BITS-1:0] rsp_point_x,
   output logic signed [dpb_pkg::COORD_BITS-1:0] rsp_point_y,
   output logic [dpb_pkg::Z_BITS-1:0]            rsp_point_z,
   output logic [dpb_pkg::COLOUR_BITS-1:0]       rsp_out_blue,
   output logic [dpb_pkg::COLOUR_BITS-1:0]       rsp_out_green,
   output logic [dpb_pkg::COLOUR_BITS-1:0]       rsp_out_red,
   output logic [dpb_pkg::INDEX_BITS-1:0]        rsp_point_index,
   output logic                                  rsp_overflow
);
   import dpb_pkg::*;

   localparam int PCB  = PIXEL_COORD_BITS;
   localparam int CW   = (PCB + 1 > WIDTH_BITS) ? PCB + 1 : WIDTH_BITS;
   localparam int DHB  = (PCB + 2 > CENTER_BITS + 1) ? PCB + 2 : CENTER_BITS + 1;
   localparam int DMB  = DHB - 1;
   localparam int ZPB  = DEPTH_BITS + RECIP_BITS;
   localparam int MB   = 2 * RECIP_BITS;
   localparam int AB   = 64;
   localparam int ZSH  = RECIP_BITS - COORD_FRAC_BITS;
   localparam logic [MB-1:0] ZRND = (MB'(1) << ZSH) >> 1;
   localparam int IDXK = (POINT_INDEX_BITS < INDEX_BITS) ? POINT_INDEX_BITS : INDEX_BITS;
   localparam int PSH  = 25;
   localparam logic [AB-1:0] PRND = AB'(1) << (PSH - 1);
   localparam int MAGB = AB - PSH;
   localparam logic [MAGB-1:0] POS_MAX = MAGB'(32'h7FFF_FFFF);
   localparam logic [MAGB-1:0] NEG_MAX = MAGB'(32'h8000_0000);

   // Configuration registers.
   logic        [RECIP_BITS-1:0]  depth_recip_ff;
   logic        [CENTER_BITS-1:0] center_x_ff;
   logic        [CENTER_BITS-1:0] center_y_ff;
   logic signed [RECIP_BITS-1:0]  recip_fx_ff;
   logic signed [RECIP_BITS-1:0]  recip_fy_ff;
   logic        [WIDTH_BITS-1:0]  frame_width_ff;
   logic        [POINTS_BITS-1:0] max_points_ff;

   // Counters.
   logic [PCB-1:0]         col_ff, col_in, col_cur;
   logic [PCB-1:0]         row_ff, row_in, row_cur;
   logic [POINTS_BITS-1:0] pts_ff, pts_in, pts_cur;
   logic [CW-1:0]          col_next;
   logic                   row_end;

   // Per-point working registers.
   logic [ZPB-1:0]               zp_ff;
   logic [Z_BITS-1:0]            z_ff;
   logic signed [DHB-1:0]        dx_ff, dy_ff, dx_in, dy_in;
   logic [DMB-1:0]               dx_mag, dy_mag, d_mag;
   logic [RECIP_BITS-1:0]        fx_mag, fy_mag;
   logic [COLOUR_BITS-1:0]       blue_ff, green_ff, red_ff;
   logic [INDEX_BITS-1:0]        idx_ff;
   logic                         ovf_ff;
   logic [MB-1:0]                zr_ff;
   logic [AB-1:0]                acc_ff;
   logic                         neg_ff;
   logic signed [COORD_BITS-1:0] x_ff, y_ff;

   // Shared multiplier and rounding.
   logic [RECIP_BITS-1:0]        mul_a, mul_b;
   logic [MB-1:0]                mul_p;
   logic [MB-1:0]                z_round;
   logic [AB-1:0]                acc_round;
   logic [MAGB-1:0]              mag;
   logic signed [COORD_BITS-1:0] coord;

   assign status.depth_zero = (req_depth_raw == '0);

   // Counter update for the pixel being accepted.
   always_comb begin
      col_cur  = req_start_of_frame ? '0 : col_ff;
      row_cur  = req_start_of_frame ? '0 : row_ff;
      pts_cur  = req_start_of_frame ? '0 : pts_ff;
      col_next = CW'(col_cur) + CW'(1);
      row_end  = (col_next >= CW'(frame_width_ff)) || col_next[PCB];
      col_in   = row_end ? '0 : col_next[PCB-1:0];
      row_in   = row_end ? row_cur + PCB'(1) : row_cur;
      pts_in   = (!status.depth_zero && pts_cur != POINTS_SAT) ?
                 pts_cur + POINTS_BITS'(1) : pts_cur;
      dx_in    = $signed(DHB'({col_cur, 1'b0})) - $signed(DHB'(center_x_ff));
      dy_in    = $signed(DHB'({row_cur, 1'b0})) - $signed(DHB'(center_y_ff));
   end

   // Magnitudes and operand selection for the shared multiplier.
   always_comb begin
      dx_mag = dx_ff[DHB-1] ? DMB'(-dx_ff) : DMB'(dx_ff);
      dy_mag = dy_ff[DHB-1] ? DMB'(-dy_ff) : DMB'(dy_ff);
      fx_mag = recip_fx_ff[RECIP_BITS-1] ? RECIP_BITS'(-recip_fx_ff) : recip_fx_ff;
      fy_mag = recip_fy_ff[RECIP_BITS-1] ? RECIP_BITS'(-recip_fy_ff) : recip_fy_ff;
      d_mag  = cmd.axis ? dy_mag : dx_mag;
      if (cmd.mul_zr) begin
         mul_a = z_ff;
         mul_b = cmd.axis ? fy_mag : fx_mag;
      end else if (cmd.mul_hi) begin
         mul_a = zr_ff[MB-1:RECIP_BITS];
         mul_b = RECIP_BITS'(d_mag);
      end else begin
         mul_a = zr_ff[RECIP_BITS-1:0];
         mul_b = RECIP_BITS'(d_mag);
      end
      mul_p = mul_a * mul_b;
   end

   // Depth rounding and coordinate rounding with saturation.
   always_comb begin
      z_round   = (MB'(zp_ff) + ZRND) >> ZSH;
      acc_round = acc_ff + PRND;
      mag       = acc_round[AB-1:PSH];
      if (neg_ff) begin
         coord = (mag >= NEG_MAX) ? $signed(32'h8000_0000) : $signed(32'd0 - mag[31:0]);
      end else begin
         coord = (mag > POS_MAX) ? $signed(32'h7FFF_FFFF) : $signed(mag[31:0]);
      end
   end

   // Configuration and counters.
   always_ff @(posedge clock) begin
      if (reset) begin
         depth_recip_ff <= DEPTH_RECIP_RST;
         center_x_ff    <= CENTER_X_HALF_RST;
         center_y_ff    <= CENTER_Y_HALF_RST;
         recip_fx_ff    <= RECIP_FX_RST;
         recip_fy_ff    <= RECIP_FY_RST;
         frame_width_ff <= FRAME_WIDTH_RST;
         max_points_ff  <= MAX_POINTS_RST;
         col_ff         <= '0;
         row_ff         <= '0;
         pts_ff         <= '0;
      end else begin
         if (csr_valid) begin
            unique case (csr_index)
               CSR_DEPTH_RECIP:   depth_recip_ff <= csr_data;
               CSR_CENTER_X_HALF: center_x_ff    <= csr_data[CENTER_BITS-1:0];
               CSR_CENTER_Y_HALF: center_y_ff    <= csr_data[CENTER_BITS-1:0];
               CSR_RECIP_FX:      recip_fx_ff    <= $signed(csr_data);
               CSR_RECIP_FY:      recip_fy_ff    <= $signed(csr_data);
               CSR_FRAME_WIDTH:   frame_width_ff <= csr_data[WIDTH_BITS-1:0];
               CSR_MAX_POINTS:    max_points_ff  <= csr_data[POINTS_BITS-1:0];
               default: ;
            endcase
         end
         if (cmd.accept) begin
            col_ff <= col_in;
            row_ff <= row_in;
            pts_ff <= pts_in;
         end
      end
   end

   // Working registers of the point in progress.
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         zp_ff    <= ZPB'(req_depth_raw) * ZPB'(depth_recip_ff);
         dx_ff    <= dx_in;
         dy_ff    <= dy_in;
         blue_ff  <= req_blue;
         green_ff <= req_green;
         red_ff   <= req_red;
         idx_ff   <= INDEX_BITS'(pts_cur[IDXK-1:0]);
         ovf_ff   <= (pts_cur >= max_points_ff);
      end
      if (cmd.zfin) begin
         z_ff <= (z_round[MB-1:Z_BITS] != '0) ? '1 : z_round[Z_BITS-1:0];
      end
      if (cmd.mul_zr) begin
         zr_ff  <= mul_p;
         neg_ff <= (cmd.axis ? dy_ff[DHB-1] : dx_ff[DHB-1]) ^
                   (cmd.axis ? recip_fy_ff[RECIP_BITS-1] : recip_fx_ff[RECIP_BITS-1]);
      end
      if (cmd.mul_lo) begin
         acc_ff <= AB'(mul_p);
      end
      if (cmd.mul_hi) begin
         acc_ff <= acc_ff + AB'({mul_p, {RECIP_BITS{1'b0}}});
      end
      if (cmd.fin) begin
         if (cmd.axis) begin
            y_ff <= coord;
         end else begin
            x_ff <= coord;
         end
      end
      if (cmd.load_out) begin
         rsp_point_x     <= x_ff;
         rsp_point_y     <= y_ff;
         rsp_point_z     <= z_ff;
         rsp_out_blue    <= blue_ff;
         rsp_out_green   <= green_ff;
         rsp_out_red     <= red_ff;
         rsp_point_index <= idx_ff;
         rsp_overflow    <= ovf_ff;
      end
   end

endmodule

>>> sv/dpb_ctrl.sv
// Sequencer of the depth pixel back-projection core: state machine and output handshake.
module dpb_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   input  dpb_pkg::dpb_status_type status,
   output dpb_pkg::dpb_cmd_type    cmd
);
   import dpb_pkg::*;

   typedef enum logic [6:0] {
      ST_IDLE  = 7'b000_0001,
      ST_ZFIN  = 7'b000_0010,
      ST_MULR  = 7'b000_0100,
      ST_MULLO = 7'b000_1000,
      ST_MULHI = 7'b001_0000,
      ST_FIN   = 7'b010_0000,
      ST_PUT   = 7'b100_0000
   } state_type;

   state_type state_ff, state_in;
   logic      axis_ff, axis_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      slot_free;

   assign req_stall = reset || (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign slot_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      axis_in  = axis_ff;
      cmd      = '0;
      cmd.axis = axis_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && !reset) begin
               cmd.accept = 1'b1;
               if (!status.depth_zero) begin
                  axis_in  = 1'b0;
                  state_in = ST_ZFIN;
               end
            end
         end
         ST_ZFIN: begin
            cmd.zfin = 1'b1;
            state_in = ST_MULR;
         end
         ST_MULR: begin
            cmd.mul_zr = 1'b1;
            state_in   = ST_MULLO;
         end
         ST_MULLO: begin
            cmd.mul_lo = 1'b1;
            state_in   = ST_MULHI;
         end
         ST_MULHI: begin
            cmd.mul_hi = 1'b1;
            state_in   = ST_FIN;
         end
         ST_FIN: begin
            cmd.fin = 1'b1;
            if (axis_ff) begin
               state_in = ST_PUT;
            end else begin
               axis_in  = 1'b1;
               state_in = ST_MULR;
            end
         end
         ST_PUT: begin
            if (slot_free) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      priority if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         axis_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         axis_ff      <= axis_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

>>> sv/dpb_checker.sv
// Port-level checker of the depth pixel back-projection core, bound to the top level.
module dpb_checker (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  req_valid,
   input logic                                  req_stall,
   input logic [dpb_pkg::DEPTH_BITS-1:0]        req_depth_raw,
   input logic                                  rsp_valid,
   input logic                                  rsp_stall,
   input logic signed [dpb_pkg::COORD_BITS-1:0] rsp_point_x,
   input logic signed [dpb_pkg::COORD_BITS-1:0] rsp_point_y,
   input logic [dpb_pkg::Z_BITS-1:0]            rsp_point_z,
   input logic [dpb_pkg::INDEX_BITS-1:0]        rsp_point_index
);

   // A pixel with depth keeps the core busy in the following cycle.
   a_busy_after_point: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_depth_raw != '0) |=> req_stall)
      else $error("core ready straight after a pixel with depth");

   // A pixel without depth leaves the core ready for the next one.
   a_ready_after_empty: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_depth_raw == '0) |=> !req_stall)
      else $error("core busy after a pixel without depth");

   // A new point appears only at the end of a computation, while input was held off.
   a_point_from_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("point appeared without a computation");

   // A stalled point stays offered and unchanged.
   a_point_held: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_point_x) &&
         $stable(rsp_point_y) && $stable(rsp_point_z) && $stable(rsp_point_index)))
      else $error("stalled point changed or was dropped");

endmodule

bind depth_pixel_backprojection_core dpb_checker u_dpb_checker (.*);

>>> tb/tb.sv
// Self-checking testbench for the depth pixel back-projection core.
module tb;
   import dpb_pkg::*;

   // Upper bound on the run, far above the slowest correct run (every pixel giving a point,
   // every point waiting out the longest receiver stall, every pixel after the longest gap).
   localparam int unsigned CYCLE_LIMIT = 2_000_000;
   // Covers, with margin, the time that a pixel with depth spends inside the core.
   localparam int DRAIN_CYCLES = 16;

   // One back-projected point as it leaves the core.
   typedef struct packed {
      logic signed [COORD_BITS-1:0] x;
      logic signed [COORD_BITS-1:0] y;
      logic [Z_BITS-1:0]            z;
      logic [COLOUR_BITS-1:0]       blue;
      logic [COLOUR_BITS-1:0]       green;
      logic [COLOUR_BITS-1:0]       red;
      logic [INDEX_BITS-1:0]        index;
      logic                         overflow;
   } point_fields_type;

   // The scoreboard carries its own copy of the registers and the pixel counters, works out the
   // point that every accepted pixel should give and keeps those points in order of arrival.
   class point_scoreboard;
      logic [RECIP_BITS-1:0]         depth_recip;
      logic [CENTER_BITS-1:0]        cx_half;
      logic [CENTER_BITS-1:0]        cy_half;
      logic signed [RECIP_BITS-1:0]  fx_recip;
      logic signed [RECIP_BITS-1:0]  fy_recip;
      logic [WIDTH_BITS-1:0]         row_length;
      logic [POINTS_BITS-1:0]        point_limit;
      logic [PIXEL_COORD_BITS_DEF-1:0] column;
      logic [PIXEL_COORD_BITS_DEF-1:0] row;
      logic [POINTS_BITS-1:0]        points_in_frame;
      point_fields_type              expected_points[$];
      int unsigned                   pixels_taken;
      int unsigned                   points_checked;
      int unsigned                   overflow_points;
      int unsigned                   mismatches;

      function new();
         depth_recip     = DEPTH_RECIP_RST;
         cx_half         = CENTER_X_HALF_RST;
         cy_half         = CENTER_Y_HALF_RST;
         fx_recip        = RECIP_FX_RST;
         fy_recip        = RECIP_FY_RST;
         row_length      = FRAME_WIDTH_RST;
         point_limit     = MAX_POINTS_RST;
         column          = '0;
         row             = '0;
         points_in_frame = '0;
         pixels_taken    = 0;
         points_checked  = 0;
         overflow_points = 0;
         mismatches      = 0;
      endfunction

      function void write_reg(csr_index_type idx, logic [CSR_DATA_BITS-1:0] data);
         case (idx)
            CSR_DEPTH_RECIP:   depth_recip = data[RECIP_BITS-1:0];
            CSR_CENTER_X_HALF: cx_half     = data[CENTER_BITS-1:0];
            CSR_CENTER_Y_HALF: cy_half     = data[CENTER_BITS-1:0];
            CSR_RECIP_FX:      fx_recip    = data[RECIP_BITS-1:0];
            CSR_RECIP_FY:      fy_recip    = data[RECIP_BITS-1:0];
            CSR_FRAME_WIDTH:   row_length  = data[WIDTH_BITS-1:0];
            CSR_MAX_POINTS:    point_limit = data[POINTS_BITS-1:0];
            default: ;
         endcase
      endfunction

      // Offset times depth times reciprocal focal length, taken down by 25 bits with rounding
      // half away from zero, then clamped to the signed 32-bit range.
      function logic [COORD_BITS-1:0] scale_offset(int offset, logic [Z_BITS-1:0] z,
                                                   logic signed [RECIP_BITS-1:0] recip);
         bit                neg;
         longint unsigned   off_mag;
         longint unsigned   recip_mag;
         longint unsigned   mag;
         neg       = (offset < 0) != (recip < 0);
         off_mag   = (offset < 0) ? longint'(-offset) : longint'(offset);
         recip_mag = (recip < 0) ? -longint'(recip) : longint'(recip);
         mag       = off_mag * longint'(z) * recip_mag;
         mag       = (mag + (64'd1 << 24)) >> 25;
         if (neg) begin
            if (mag >= 64'h8000_0000)
               return 32'h8000_0000;
            return -mag[31:0];
         end
         if (mag > 64'h7FFF_FFFF)
            return 32'h7FFF_FFFF;
         return mag[31:0];
      endfunction

      function void note_pixel(logic sof, logic [DEPTH_BITS-1:0] depth,
                               logic [COLOUR_BITS-1:0] b, logic [COLOUR_BITS-1:0] g,
                               logic [COLOUR_BITS-1:0] r);
         longint unsigned  depth_prod;
         longint unsigned  depth_rounded;
         point_fields_type pt;
         int               col_next;
         pixels_taken++;
         if (sof) begin
            column          = '0;
            row             = '0;
            points_in_frame = '0;
         end
         if (depth != '0) begin
            depth_prod    = longint'(depth) * longint'(depth_recip);
            depth_rounded = (depth_prod + (64'd1 << (23 - COORD_FRAC_BITS_DEF)))
                            >> (24 - COORD_FRAC_BITS_DEF);
            pt.z          = (depth_rounded > 64'hFF_FFFF) ? '1 : depth_rounded[Z_BITS-1:0];
            pt.x          = scale_offset(2 * int'(column) - int'(cx_half), pt.z, fx_recip);
            pt.y          = scale_offset(2 * int'(row) - int'(cy_half), pt.z, fy_recip);
            pt.blue       = b;
            pt.green      = g;
            pt.red        = r;
            pt.index      = points_in_frame[INDEX_BITS-1:0];
            pt.overflow   = points_in_frame >= point_limit;
            expected_points = {expected_points, pt};
            if (points_in_frame != POINTS_SAT)
               points_in_frame++;
         end
         // Raster advance: the row ends when the next column reaches the frame width or the column range.
         col_next = int'(column) + 1;
         if (col_next >= int'(row_length) || col_next >= (1 << PIXEL_COORD_BITS_DEF)) begin
            column = '0;
            row    = row + 1'b1;
         end else begin
            column = col_next[PIXEL_COORD_BITS_DEF-1:0];
         end
      endfunction

      function void compare_field(string name, longint want, longint got);
         if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
         end
      endfunction

      function void check_point(point_fields_type got);
         point_fields_type want;
         if (expected_points.size() == 0) begin
            $error("point transfer with no point outstanding");
            mismatches++;
            return;
         end
         want = expected_points.pop_front();
         points_checked++;
         if (want.overflow)
            overflow_points++;
         compare_field("point_x", want.x, got.x);
         compare_field("point_y", want.y, got.y);
         compare_field("point_z", want.z, got.z);
         compare_field("out_blue", want.blue, got.blue);
         compare_field("out_green", want.green, got.green);
         compare_field("out_red", want.red, got.red);
         compare_field("point_index", want.index, got.index);
         compare_field("overflow", want.overflow, got.overflow);
      endfunction

      function int pending();
         return expected_points.size();
      endfunction
   endclass

   logic                     clock = 1'b0;
   logic                     reset;
   logic                     req_valid;
   logic                     req_stall;
   logic                     req_start_of_frame;
   logic [DEPTH_BITS-1:0]    req_depth_raw;
   logic [COLOUR_BITS-1:0]   req_blue;
   logic [COLOUR_BITS-1:0]   req_green;
   logic [COLOUR_BITS-1:0]   req_red;
   logic                     rsp_valid;
   logic                     rsp_stall;
   logic signed [COORD_BITS-1:0] rsp_point_x;
   logic signed [COORD_BITS-1:0] rsp_point_y;
   logic [Z_BITS-1:0]        rsp_point_z;
   logic [COLOUR_BITS-1:0]   rsp_out_blue;
   logic [COLOUR_BITS-1:0]   rsp_out_green;
   logic [COLOUR_BITS-1:0]   rsp_out_red;
   logic [INDEX_BITS-1:0]    rsp_point_index;
   logic                     rsp_overflow;
   logic                     csr_valid;
   logic                     csr_ready;
   logic [CSR_IDX_BITS-1:0]  csr_index;
   logic [CSR_DATA_BITS-1:0] csr_data;

   point_scoreboard sb;
   int unsigned     cycles = 0;
   int              burst_left;
   bit              no_gaps;
   int unsigned     settings_used;

   depth_pixel_backprojection_core uut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_start_of_frame (req_start_of_frame),
      .req_depth_raw      (req_depth_raw),
      .req_blue           (req_blue),
      .req_green          (req_green),
      .req_red            (req_red),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_point_x        (rsp_point_x),
      .rsp_point_y        (rsp_point_y),
      .rsp_point_z        (rsp_point_z),
      .rsp_out_blue       (rsp_out_blue),
      .rsp_out_green      (rsp_out_green),
      .rsp_out_red        (rsp_out_red),
      .rsp_point_index    (rsp_point_index),
      .rsp_overflow       (rsp_overflow),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Watchdog: a hung handshake or a point that never arrives ends the run here.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d points outstanding", cycles, sb.pending());
         $display("tb NOT OK");
         $finish;
      end
   end

   // Monitor: every transfer on the three channels is seen at the rising edge, with the
   // values that were settled since the previous falling edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready)
            sb.write_reg(csr_index_type'(csr_index), csr_data);
         if (req_valid && !req_stall)
            sb.note_pixel(req_start_of_frame, req_depth_raw, req_blue, req_green, req_red);
         if (rsp_valid && !rsp_stall)
            sb.check_point('{x: rsp_point_x, y: rsp_point_y, z: rsp_point_z,
                             blue: rsp_out_blue, green: rsp_out_green, red: rsp_out_red,
                             index: rsp_point_index, overflow: rsp_overflow});
      end
   end

   // Receiver back-pressure. The pattern switches at random between no stall at all, a coin
   // toss on every cycle, and solid stalls alternating with solid openings of random length,
   // so that stalls land on every stage of the core's work and on its held output register.
   int stall_mode;
   int stretch_left;
   int hold_left;
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall    <= 1'b0;
         stall_mode   <= 0;
         stretch_left <= 0;
         hold_left    <= 0;
      end else begin
         if (stretch_left == 0) begin
            stall_mode   <= $urandom_range(0, 2);
            stretch_left <= $urandom_range(50, 300);
         end else begin
            stretch_left <= stretch_left - 1;
         end
         case (stall_mode)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= 1'($urandom_range(0, 1));
            default: begin
               if (hold_left == 0) begin
                  hold_left <= $urandom_range(1, 20);
                  rsp_stall <= !rsp_stall;
               end else begin
                  hold_left <= hold_left - 1;
               end
            end
         endcase
      end
   end

   // Offers one pixel and returns at the falling edge after its transfer. The sender works
   // in bursts; between bursts valid may drop for a random gap unless this phase runs gap-free.
   task automatic send_pixel(logic sof, logic [DEPTH_BITS-1:0] depth,
                             logic [COLOUR_BITS-1:0] b, logic [COLOUR_BITS-1:0] g,
                             logic [COLOUR_BITS-1:0] r);
      int gap;
      if (burst_left <= 0) begin
         gap = no_gaps ? 0 : $urandom_range(0, 6);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      req_valid          <= 1'b1;
      req_start_of_frame <= sof;
      req_depth_raw      <= depth;
      req_blue           <= b;
      req_green          <= g;
      req_red            <= r;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
      burst_left--;
   endtask

   // Random pixel content: zero depth, full scale and small depths all turn up often, and
   // a new frame starts now and then.
   task automatic send_random_pixel(bit force_sof);
      logic [DEPTH_BITS-1:0] depth;
      logic                  sof;
      case ($urandom_range(0, 19))
         0, 1, 2: depth = '0;
         3:       depth = '1;
         4, 5:    depth = DEPTH_BITS'($urandom_range(1, 255));
         default: depth = DEPTH_BITS'($urandom_range(0, 65535));
      endcase
      sof = force_sof || ($urandom_range(0, 47) == 0);
      send_pixel(sof, depth, COLOUR_BITS'($urandom_range(0, 255)),
                 COLOUR_BITS'($urandom_range(0, 255)), COLOUR_BITS'($urandom_range(0, 255)));
   endtask

   // Lets every outstanding point arrive, then waits out a pixel that may still be in the
   // core without a point to show for it. The core is idle afterwards.
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   // Writes one register; csr_valid stays high so that back-to-back writes need no second
   // assignment in the same step, and the caller lowers it after the last one.
   task automatic write_reg(csr_index_type idx, logic [CSR_DATA_BITS-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
   endtask

   task automatic load_settings(logic [RECIP_BITS-1:0] depth_recip,
                                logic [CENTER_BITS-1:0] cx, logic [CENTER_BITS-1:0] cy,
                                logic [RECIP_BITS-1:0] fx, logic [RECIP_BITS-1:0] fy,
                                logic [WIDTH_BITS-1:0] row_len,
                                logic [POINTS_BITS-1:0] limit);
      wait_idle();
      write_reg(CSR_DEPTH_RECIP, depth_recip);
      write_reg(CSR_CENTER_X_HALF, CSR_DATA_BITS'(cx));
      write_reg(CSR_CENTER_Y_HALF, CSR_DATA_BITS'(cy));
      write_reg(CSR_RECIP_FX, fx);
      write_reg(CSR_RECIP_FY, fy);
      write_reg(CSR_FRAME_WIDTH, CSR_DATA_BITS'(row_len));
      write_reg(CSR_MAX_POINTS, CSR_DATA_BITS'(limit));
      csr_valid <= 1'b0;
      settings_used++;
      no_gaps = ($urandom_range(0, 3) == 0);
   endtask

   function automatic logic [RECIP_BITS-1:0] random_focal();
      logic [RECIP_BITS-1:0] mag;
      if ($urandom_range(0, 3) == 0)
         return RECIP_BITS'($urandom_range(0, 24'hFF_FFFF));
      mag = RECIP_BITS'($urandom_range(20000, 60000));
      return $urandom_range(0, 1) ? -mag : mag;
   endfunction

   task automatic load_random_settings();
      logic [RECIP_BITS-1:0]  depth_recip;
      logic [WIDTH_BITS-1:0]  row_len;
      logic [POINTS_BITS-1:0] limit;
      depth_recip = ($urandom_range(0, 3) == 0) ? RECIP_BITS'($urandom_range(0, 24'hFF_FFFF))
                                                : RECIP_BITS'($urandom_range(1000, 20000));
      case ($urandom_range(0, 3))
         0, 1:    row_len = WIDTH_BITS'($urandom_range(1, 8));
         2:       row_len = WIDTH_BITS'($urandom_range(1, 4095));
         default: row_len = WIDTH_BITS'(640);
      endcase
      limit = ($urandom_range(0, 1) == 0) ? POINTS_BITS'($urandom_range(0, 60))
                                          : POINTS_BITS'($urandom_range(0, 524288));
      load_settings(depth_recip, CENTER_BITS'($urandom_range(0, 8191)),
                    CENTER_BITS'($urandom_range(0, 8191)),
                    random_focal(), random_focal(), row_len, limit);
   endtask

   initial begin
      sb                 = new();
      burst_left         = 0;
      no_gaps            = 1'b0;
      settings_used      = 0;
      reset              = 1'b1;
      req_valid          = 1'b0;
      req_start_of_frame = 1'b0;
      req_depth_raw      = '0;
      req_blue           = '0;
      req_green          = '0;
      req_red            = '0;
      csr_valid          = 1'b0;
      csr_index          = CSR_DEPTH_RECIP;
      csr_data           = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed pixels under the reset settings: full and smallest depth, colour extremes,
      // zero depth with and without a new frame, and a frame restart in mid-row.
      send_pixel(1'b1, 16'hFFFF, 8'hFF, 8'h00, 8'hFF);
      send_pixel(1'b0, 16'h0000, 8'h12, 8'h34, 8'h56);
      send_pixel(1'b0, 16'h0001, 8'h00, 8'hFF, 8'h00);
      send_pixel(1'b0, 16'd5000, 8'hAA, 8'h55, 8'hAA);
      send_pixel(1'b0, 16'h8000, 8'h55, 8'hAA, 8'h55);
      send_pixel(1'b1, 16'h0000, 8'hFF, 8'hFF, 8'hFF);
      send_pixel(1'b0, 16'h7FFF, 8'h01, 8'h80, 8'hFE);
      send_pixel(1'b1, 16'd1234, 8'h00, 8'h00, 8'h00);
      repeat (6) send_random_pixel(1'b0);

      // Every register but the point limit at its upper extreme: for large depths z and both
      // coordinates saturate, x and y towards the negative end.
      load_settings(24'hFF_FFFF, 13'h1FFF, 13'h1FFF, 24'h7F_FFFF, 24'h7F_FFFF, 12'hFFF,
                    20'd524288);
      send_random_pixel(1'b1);
      repeat (40) send_random_pixel(1'b0);

      // Every register but the frame width at its lower extreme: z is zero, one pixel per row and
      // every point flagged as overflow.
      load_settings(24'h00_0000, 13'h0000, 13'h0000, 24'h80_0000, 24'h80_0000, 12'd1, 20'd0);
      send_random_pixel(1'b1);
      repeat (40) send_random_pixel(1'b0);

      // Mixed extremes: positive saturation on y, a two-pixel row and overflow after three.
      load_settings(24'hFF_FFFF, 13'h0000, 13'h1FFF, 24'h80_0000, 24'h80_0000, 12'd2, 20'd3);
      send_random_pixel(1'b1);
      repeat (40) send_random_pixel(1'b0);

      // Zero frame width: every pixel ends its row, so the row counter climbs by one on
      // every pixel. Most pixels have no depth.
      load_settings(24'd3355, 13'd639, 13'd479, 24'd34865, -24'sd34953, 12'd0, 20'd100);
      send_pixel(1'b1, 16'd3000, 8'h10, 8'h20, 8'h30);
      for (int i = 0; i < 200; i++)
         send_pixel(1'b0, ($urandom_range(0, 39) == 0) ? DEPTH_BITS'($urandom_range(1, 65535))
                                                        : 16'd0,
                    COLOUR_BITS'($urandom_range(0, 255)), COLOUR_BITS'($urandom_range(0, 255)),
                    COLOUR_BITS'($urandom_range(0, 255)));

      // Random settings, each with raster frames of random pixels.
      for (int p = 0; p < 5; p++) begin
         load_random_settings();
         send_random_pixel(1'b1);
         repeat (139) send_random_pixel(1'b0);
      end

      wait_idle();
      $display("%0d pixels taken under %0d register settings;", sb.pixels_taken,
               settings_used);
      $display("%0d points checked, %0d of them overflow, %0d field mismatches found",
               sb.points_checked, sb.overflow_points, sb.mismatches);
      if (sb.mismatches == 0)
         $display("tb OK");
      else
         $display("tb NOT OK");
      $finish;
   end
endmodule
